FILE: src/mct_pkg.sv
package mct_pkg;

  localparam int TIME_W     = 48;
  localparam int DATE_W     = 27;
  localparam int HITS_W     = 3;
  localparam int REQ_W      = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_STREAMS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_HITS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_DATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_DATE    = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_WINDOW      = 32'd1000;
  localparam logic [REQ_W-1:0]      RST_REQ_STREAMS = 3'd3;
  localparam logic [REQ_W-1:0]      RST_REQ_HITS    = 3'd2;
  localparam logic [DATE_W-1:0]     RST_START_DATE  = 27'd20040400;
  localparam logic [DATE_W-1:0]     RST_END_DATE    = 27'd20100000;

  // hard lower bound on event dates, applied on top of start_date
  localparam logic [DATE_W-1:0] FIXED_EARLIEST_DATE = 27'd20040400;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] window_ns;
    logic [REQ_W-1:0]      required_streams;
    logic [REQ_W-1:0]      required_hits;
    logic [DATE_W-1:0]     start_date;
    logic [DATE_W-1:0]     end_date;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    logic              is_end;
    logic [1:0]        stream;
    logic [TIME_W-1:0] ts;
    logic [HITS_W-1:0] hits;
  } cmd_t;

  typedef struct packed {
    logic              is_coincidence;
    logic [31:0]       coincidence_number;
    logic [2:0]        streams_in_window;
    logic [3:0]        member_mask;
    logic [1:0]        earliest_stream;
    logic [TIME_W-1:0] earliest_time_ns;
    logic [3:0]        consumed_mask;
    logic              all_done;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_SCAN,
    BK_COUNT,
    BK_OUT
  } back_state_e;

endpackage

FILE: src/mct_front.sv
module mct_front #(
  parameter int NUM_STREAMS = 4
) (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [1:0]                  stream_i,
  input  logic [mct_pkg::TIME_W-1:0]  timestamp_ns_i,
  input  logic [mct_pkg::HITS_W-1:0]  hit_count_i,
  input  logic [mct_pkg::DATE_W-1:0]  event_date_i,
  input  logic                        malformed_i,
  input  mct_pkg::cfg_t               cfg_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output mct_pkg::cmd_t               cmd_o
);
  import mct_pkg::*;

  logic in_range;
  logic date_ok;
  logic keep;

  assign in_range = (32'(stream_i) < NUM_STREAMS);
  assign date_ok  = !malformed_i && (event_date_i > cfg_i.start_date) &&
                    (event_date_i <= cfg_i.end_date) &&
                    (event_date_i > FIXED_EARLIEST_DATE);
  // dropped events never change state, so they stop here
  assign keep = in_range && (kind_i || date_ok);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  assign cmd_o.is_end = kind_i;
  assign cmd_o.stream = stream_i;
  assign cmd_o.ts     = timestamp_ns_i;
  assign cmd_o.hits   = hit_count_i;

endmodule

FILE: src/mct_queue.sv
module mct_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mct_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output mct_pkg::cmd_t data_o
);
  import mct_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

FILE: src/mct_back.sv
module mct_back #(
  parameter int NUM_STREAMS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mct_pkg::cfg_t   cfg_i,
  input  logic            cmd_valid_i,
  input  mct_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output mct_pkg::result_t res_o
);
  import mct_pkg::*;

  localparam int SW    = $clog2(NUM_STREAMS);
  localparam int CW    = $clog2(NUM_STREAMS + 1);
  localparam int CMP_W = (CW > REQ_W) ? CW : REQ_W;

  back_state_e state_q, state_d;

  logic [NUM_STREAMS-1:0] valid_q, valid_d;
  logic [NUM_STREAMS-1:0] ended_q, ended_d;
  logic [TIME_W-1:0]      head_ts_q   [NUM_STREAMS];
  logic [HITS_W-1:0]      head_hits_q [NUM_STREAMS];

  logic [SW-1:0]          idx_q, idx_d;
  logic [SW-1:0]          best_idx_q, best_idx_d;
  logic [TIME_W-1:0]      best_ts_q, best_ts_d;
  logic                   found_q, found_d;
  logic [CW-1:0]          count_q, count_d;
  logic [NUM_STREAMS-1:0] members_q, members_d;
  logic                   hits_ok_q, hits_ok_d;
  logic                   was_done_q, was_done_d;
  logic                   done_q, done_d;
  logic [31:0]            coin_cnt_q, coin_cnt_d;
  result_t                res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  logic                   all_ended;
  logic                   ready_eval;
  logic [SW-1:0]          wr_idx;
  logic                   wr_head;
  logic [TIME_W-1:0]      sel_ts;
  logic [TIME_W-1:0]      diff;
  logic                   last;
  logic                   in_win;
  logic                   coinc;
  logic                   load;
  logic [NUM_STREAMS-1:0] consumed;

  assign all_ended  = &ended_q;
  assign ready_eval = (&(ended_q | valid_q)) && !all_ended;
  assign wr_idx     = SW'(cmd_i.stream);
  assign wr_head    = (state_q == BK_IDLE) && cmd_valid_i && !cmd_i.is_end &&
                      !ended_q[wr_idx] && !valid_q[wr_idx];
  assign cmd_pop_o  = (state_q == BK_IDLE) && cmd_valid_i;
  assign sel_ts     = head_ts_q[idx_q];
  assign diff       = sel_ts - best_ts_q;
  assign last       = (idx_q == SW'(NUM_STREAMS - 1));
  assign in_win     = !ended_q[idx_q] &&
                      ((idx_q == best_idx_q) || (diff <= TIME_W'(cfg_i.window_ns)));
  assign coinc      = (CMP_W'(count_q) >= CMP_W'(cfg_i.required_streams)) && hits_ok_q;
  assign load       = (state_q == BK_OUT) && (!res_valid_q || res_ready_i);

  always_comb begin
    consumed = '0;
    if (coinc) begin
      consumed = members_q;
    end else begin
      consumed[best_idx_q] = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    ended_d     = ended_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_ts_d   = best_ts_q;
    found_d     = found_q;
    count_d     = count_q;
    members_d   = members_q;
    hits_ok_d   = hits_ok_q;
    was_done_d  = was_done_q;
    done_d      = done_q;
    coin_cnt_d  = coin_cnt_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          was_done_d = all_ended;
          if (cmd_i.is_end) begin
            ended_d[wr_idx] = 1'b1;
            valid_d[wr_idx] = 1'b0;
          end else if (wr_head) begin
            valid_d[wr_idx] = 1'b1;
          end
          state_d = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (!was_done_q && all_ended) begin
          done_d  = 1'b1;
          state_d = BK_OUT;
        end else if (ready_eval) begin
          done_d  = 1'b0;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = BK_SCAN;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_SCAN: begin
        // strict less-than keeps the lower stream on a tie
        if (!ended_q[idx_q] && (!found_q || sel_ts < best_ts_q)) begin
          found_d    = 1'b1;
          best_idx_d = idx_q;
          best_ts_d  = sel_ts;
        end
        if (last) begin
          idx_d     = '0;
          count_d   = '0;
          members_d = '0;
          hits_ok_d = 1'b1;
          state_d   = BK_COUNT;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      BK_COUNT: begin
        if (in_win) begin
          count_d          = count_q + CW'(1);
          members_d[idx_q] = 1'b1;
          if (head_hits_q[idx_q] < cfg_i.required_hits) begin
            hits_ok_d = 1'b0;
          end
        end
        if (last) begin
          state_d = BK_OUT;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      BK_OUT: begin
        if (load) begin
          res_valid_d = 1'b1;
          res_d       = '0;
          if (done_q) begin
            res_d.all_done = 1'b1;
          end else begin
            res_d.is_coincidence     = coinc;
            res_d.coincidence_number = coin_cnt_q;
            res_d.streams_in_window  = 3'(count_q);
            res_d.member_mask        = 4'(members_q);
            res_d.earliest_stream    = 2'(best_idx_q);
            res_d.earliest_time_ns   = best_ts_q;
            res_d.consumed_mask      = 4'(consumed);
            valid_d                  = valid_q & ~consumed;
            if (coinc) begin
              coin_cnt_d = coin_cnt_q + 32'd1;
            end
          end
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      valid_q     <= '0;
      ended_q     <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      members_q   <= '0;
      hits_ok_q   <= 1'b0;
      was_done_q  <= 1'b0;
      done_q      <= 1'b0;
      coin_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ended_q     <= ended_d;
      idx_q       <= idx_d;
      best_idx_q  <= best_idx_d;
      found_q     <= found_d;
      count_q     <= count_d;
      members_q   <= members_d;
      hits_ok_q   <= hits_ok_d;
      was_done_q  <= was_done_d;
      done_q      <= done_d;
      coin_cnt_q  <= coin_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_ts_q <= best_ts_d;
    res_q     <= res_d;
    if (wr_head) begin
      head_ts_q[wr_idx]   <= cmd_i.ts;
      head_hits_q[wr_idx] <= cmd_i.hits;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_scan_has_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> !all_ended)
    else $error("scan started with every stream ended");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT && !done_q) |-> ($countones(members_q) == int'(count_q)))
    else $error("window count disagrees with member mask");

  a_eval_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !done_q) |=> !ready_eval)
    else $error("still ready to evaluate after consuming heads");

  a_cnt_only_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_OUT) |=> $stable(coin_cnt_q))
    else $error("coincidence count moved outside result load");

endmodule

FILE: src/multi_stream_coincidence_trigger.sv
// An event that completes a set of heads passes the evaluator's check, scan (earliest
// search), count and output states; output waits until the result register is free. An
// item with no result goes from check back to idle. The evaluator takes no new command until
// it is back in idle, and visits one stream per cycle for the earliest search and the count.
// A two-entry command queue and the output register let input and output stall apart.
// Reset (rst_ni low, asynchronous) clears head valid flags, ended flags, counter and queue,
// and loads the configuration registers with their defaults.
module multi_stream_coincidence_trigger #(
  parameter int NUM_STREAMS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mct_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [1:0]                      stream_i,
  input  logic [mct_pkg::TIME_W-1:0]      timestamp_ns_i,
  input  logic [mct_pkg::HITS_W-1:0]      hit_count_i,
  input  logic [mct_pkg::DATE_W-1:0]      event_date_i,
  input  logic                            malformed_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_coincidence_o,
  output logic [31:0]                     coincidence_number_o,
  output logic [2:0]                      streams_in_window_o,
  output logic [3:0]                      member_mask_o,
  output logic [1:0]                      earliest_stream_o,
  output logic [mct_pkg::TIME_W-1:0]      earliest_time_ns_o,
  output logic [3:0]                      consumed_mask_o,
  output logic                            all_done_o
);
  import mct_pkg::*;

  cfg_t    cfg_q, cfg_d;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    q_full;
  logic    push;
  logic    q_valid;
  logic    pop;
  result_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW:      cfg_d.window_ns        = cfg_data_i;
        REG_REQ_STREAMS: cfg_d.required_streams = cfg_data_i[REQ_W-1:0];
        REG_REQ_HITS:    cfg_d.required_hits    = cfg_data_i[REQ_W-1:0];
        REG_START_DATE:  cfg_d.start_date       = cfg_data_i[DATE_W-1:0];
        REG_END_DATE:    cfg_d.end_date         = cfg_data_i[DATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ns        <= RST_WINDOW;
      cfg_q.required_streams <= RST_REQ_STREAMS;
      cfg_q.required_hits    <= RST_REQ_HITS;
      cfg_q.start_date       <= RST_START_DATE;
      cfg_q.end_date         <= RST_END_DATE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mct_front #(
    .NUM_STREAMS(NUM_STREAMS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .stream_i      (stream_i),
    .timestamp_ns_i(timestamp_ns_i),
    .hit_count_i   (hit_count_i),
    .event_date_i  (event_date_i),
    .malformed_i   (malformed_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  mct_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (pop_cmd)
  );

  mct_back #(
    .NUM_STREAMS(NUM_STREAMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(q_valid),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (pop),
    .res_valid_o(out_valid_o),
    .res_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign is_coincidence_o     = res.is_coincidence;
  assign coincidence_number_o = res.coincidence_number;
  assign streams_in_window_o  = res.streams_in_window;
  assign member_mask_o        = res.member_mask;
  assign earliest_stream_o    = res.earliest_stream;
  assign earliest_time_ns_o   = res.earliest_time_ns;
  assign consumed_mask_o      = res.consumed_mask;
  assign all_done_o           = res.all_done;

endmodule
